FILE: hw/rtl/hbbc_pkg.sv
`default_nettype none
package hbbc_pkg;
  localparam int NumBuffersDefault = 32;
  localparam int NumBucketsDefault = 13;
  localparam int LinkW = 6;
  localparam logic [LinkW-1:0] LinkNone = 6'd63;
  localparam int CountW = 8;
  localparam logic [CountW-1:0] CountMax = 8'd255;
  localparam logic [15:0] DeviceUnused = 16'hFFFF;

  localparam logic [1:0] ModeGet = 2'd0;
  localparam logic [1:0] ModeRelease = 2'd1;
  localparam logic [1:0] ModePin = 2'd2;
  localparam logic [1:0] ModeUnpin = 2'd3;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusNoFree = 2'd1;
  localparam logic [1:0] StatusUnder = 2'd2;
  localparam logic [1:0] StatusOver = 2'd3;

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StHash   = 9'b000000010,
    StSearch = 9'b000000100,
    StScanB  = 9'b000001000,
    StScan   = 9'b000010000,
    StGrant  = 9'b000100000,
    StCount  = 9'b001000000,
    StFail   = 9'b010000000,
    StOut    = 9'b100000000
  } state_t;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic search_init;
    logic search_step;
    logic scan_bucket;
    logic scan_step;
    logic grant;
    logic count_op;
    logic fail;
  } cmd_t;

  typedef struct packed {
    logic is_get;
    logic hash_done;
    logic hit;
    logic search_end;
    logic zero_here;
    logic bucket_last;
  } sts_t;
endpackage
`default_nettype wire

FILE: hw/rtl/hbbc_ctrl.sv
`default_nettype none
module hbbc_ctrl import hbbc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t state, state_next;

  assign in_ready = (state == StIdle);
  assign out_valid = (state == StOut);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      StIdle: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = StHash;
      end
      StHash: begin
        if (!sts.is_get) begin
          state_next = StCount;
        end else if (sts.hash_done) begin
          cmd.search_init = 1'b1;
          state_next = StSearch;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      StSearch: begin
        if (sts.search_end) begin
          cmd.scan_bucket = 1'b1;
          state_next = StScan;
        end else if (sts.hit) begin
          state_next = StCount;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      StScanB: begin
        cmd.scan_bucket = 1'b1;
        state_next = StScan;
      end
      StScan: begin
        if (sts.search_end) begin
          state_next = sts.bucket_last ? StFail : StScanB;
        end else if (sts.zero_here) begin
          state_next = StGrant;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      StGrant: begin
        cmd.grant = 1'b1;
        state_next = StOut;
      end
      StCount: begin
        cmd.count_op = 1'b1;
        state_next = StOut;
      end
      StFail: begin
        cmd.fail = 1'b1;
        state_next = StOut;
      end
      StOut: if (out_ready) begin
        state_next = StIdle;
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= StIdle;
    else state <= state_next;
  end
endmodule
`default_nettype wire

FILE: hw/rtl/hbbc_dp.sv
`default_nettype none
module hbbc_dp import hbbc_pkg::*; #(
  parameter int NUM_BUFFERS = NumBuffersDefault,
  parameter int NUM_BUCKETS = NumBucketsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] device,
  input  wire logic [31:0] block_number,
  input  wire logic [4:0]  buffer_slot,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  output logic [4:0]       slot_out,
  output logic             needs_fill,
  output logic [1:0]       status
);
  localparam int BktW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int IdxW = $clog2(NUM_BUFFERS);
  localparam int RemW = BktW + 1;
  localparam int RemDepth = 1 << BktW;
  localparam logic [RemW-1:0] Mod = RemW'(NUM_BUCKETS);

  logic [15:0] tag_device [NUM_BUFFERS];
  logic [31:0] tag_block [NUM_BUFFERS];
  logic [CountW-1:0] ref_count [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] filled;
  logic [LinkW-1:0] next_link [NUM_BUFFERS];
  logic [LinkW-1:0] bucket_head [NUM_BUCKETS];

  logic [1:0] req_mode;
  logic [15:0] req_dev;
  logic [31:0] req_blk;
  logic [4:0] req_slot;
  logic [31:0] hash_sh;
  logic [2:0] hash_cnt;
  logic [BktW-1:0] rem;
  logic [LinkW-1:0] cur, prev;
  logic [BktW-1:0] scan_b;
  logic [6:0] steps;
  logic first_scan;

  logic [BktW-1:0] byte_mod [256];
  logic [BktW-1:0] rem_mul [RemDepth];
  logic [RemW-1:0] rem_sum;
  logic [BktW-1:0] h;
  logic [BktW-1:0] sb_sel;
  logic cur_ok, prev_ok, slot_ok;
  logic [IdxW-1:0] ci, pi, si;

  // The bucket is found one byte per cycle, most significant byte first.
  for (genvar g = 0; g < 256; g++) begin : g_byte_mod
    assign byte_mod[g] = BktW'(g % NUM_BUCKETS);
  end
  for (genvar g = 0; g < RemDepth; g++) begin : g_rem_mul
    assign rem_mul[g] = BktW'((g * 256) % NUM_BUCKETS);
  end

  assign rem_sum = RemW'(rem_mul[rem]) + RemW'(byte_mod[hash_sh[31:24]]);
  assign h = rem;
  assign cur_ok = (cur < LinkW'(NUM_BUFFERS));
  assign prev_ok = (prev < LinkW'(NUM_BUFFERS));
  assign ci = cur[IdxW-1:0];
  assign pi = prev[IdxW-1:0];
  assign si = IdxW'(req_slot);
  assign slot_ok = ({1'b0, req_slot} < LinkW'(NUM_BUFFERS));
  assign sb_sel = first_scan ? '0 : BktW'(scan_b + 1'b1);

  always_comb begin
    sts.is_get = (req_mode == ModeGet);
    sts.hash_done = hash_cnt[2];
    sts.hit = cur_ok && tag_device[ci] == req_dev && tag_block[ci] == req_blk;
    sts.search_end = !cur_ok || steps >= 7'(NUM_BUFFERS);
    sts.zero_here = cur_ok && ref_count[ci] == '0;
    sts.bucket_last = (32'(scan_b) + 32'd1 >= 32'(NUM_BUCKETS));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode <= mode;
      req_dev <= device;
      req_blk <= block_number;
      req_slot <= buffer_slot;
      hash_sh <= block_number;
      hash_cnt <= '0;
      rem <= '0;
      scan_b <= '0;
    end
    if (cmd.hash_step) begin
      hash_sh <= {hash_sh[23:0], 8'd0};
      hash_cnt <= hash_cnt + 3'd1;
      if (rem_sum >= Mod) rem <= BktW'(rem_sum - Mod);
      else rem <= rem_sum[BktW-1:0];
    end
    if (cmd.search_init) begin
      cur <= bucket_head[h];
      steps <= '0;
      first_scan <= 1'b1;
    end
    if (cmd.search_step || cmd.scan_step) begin
      prev <= cur;
      cur <= next_link[ci];
      steps <= steps + 7'd1;
    end
    if (cmd.scan_bucket) begin
      scan_b <= sb_sel;
      cur <= bucket_head[sb_sel];
      prev <= LinkNone;
      steps <= '0;
      first_scan <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag_device[i] <= DeviceUnused;
        tag_block[i] <= '0;
        ref_count[i] <= '0;
        next_link[i] <= (i == 0) ? LinkNone : LinkW'(i - 1);
      end
      filled <= '0;
      for (int j = 0; j < NUM_BUCKETS; j++) bucket_head[j] <= LinkNone;
      bucket_head[0] <= LinkW'(NUM_BUFFERS - 1);
    end else begin
      if (cmd.grant) begin
        tag_device[ci] <= req_dev;
        tag_block[ci] <= req_blk;
        ref_count[ci] <= CountW'(1);
        filled[ci] <= 1'b1;
        if (prev_ok) next_link[pi] <= next_link[ci];
        if (scan_b == h) begin
          next_link[ci] <= prev_ok ? bucket_head[h] : next_link[ci];
        end else begin
          bucket_head[scan_b] <= prev_ok ? bucket_head[scan_b] : next_link[ci];
          next_link[ci] <= bucket_head[h];
        end
        bucket_head[h] <= cur;
        slot_out <= cur[4:0];
        needs_fill <= 1'b1;
        status <= StatusOk;
      end
      if (cmd.fail) begin
        slot_out <= '0;
        needs_fill <= 1'b0;
        status <= StatusNoFree;
      end
      if (cmd.count_op) begin
        needs_fill <= 1'b0;
        status <= StatusOk;
        if (sts.is_get) begin
          slot_out <= cur[4:0];
          if (ref_count[ci] >= CountMax) begin
            status <= StatusOver;
          end else begin
            ref_count[ci] <= ref_count[ci] + CountW'(1);
            needs_fill <= !filled[ci];
            filled[ci] <= 1'b1;
          end
        end else begin
          slot_out <= req_slot;
          if (slot_ok) begin
            if (req_mode == ModePin) begin
              if (ref_count[si] >= CountMax) status <= StatusOver;
              else ref_count[si] <= ref_count[si] + CountW'(1);
            end else if (ref_count[si] == '0) begin
              status <= StatusUnder;
            end else begin
              ref_count[si] <= ref_count[si] - CountW'(1);
            end
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/hashed_block_buffer_cache.sv
`default_nettype none
// A release, pin or unpin goes from the hash state to the count state, then presents its result.
// A get first hashes the block number into a bucket, searches that bucket's list and, on a
// hit, counts the reference; a miss scans each bucket's list in turn for a buffer with a
// zero count to grant, and fails with no free buffer when every bucket has been scanned.
// One item is in flight at a time; the next is accepted the cycle after the result is taken.
// Synchronous reset returns all tags, counts and bucket lists to their reset state.
module hashed_block_buffer_cache import hbbc_pkg::*; #(
  parameter int NUM_BUFFERS = NumBuffersDefault,
  parameter int NUM_BUCKETS = NumBucketsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] device,
  input  wire logic [31:0] block_number,
  input  wire logic [4:0]  buffer_slot,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       slot_out,
  output logic             needs_fill,
  output logic [1:0]       status
);
  cmd_t cmd;
  sts_t sts;

  hbbc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  hbbc_dp #(.NUM_BUFFERS(NUM_BUFFERS), .NUM_BUCKETS(NUM_BUCKETS)) u_dp (
    .clk, .rst, .mode, .device, .block_number, .buffer_slot, .cmd, .sts,
    .slot_out, .needs_fill, .status
  );
endmodule
`default_nettype wire
